// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_IN_W  = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 2'd3;

    // control broadcast to the window cells
    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic shift;    // mismatch: each cell takes its upper neighbor's candidate, the top cell zero
    } t_win_ctl;

    // control broadcast to the output cells
    typedef struct packed {
        logic load;     // a new burst enters all lanes
        logic pop;      // head lane was taken, move down one lane
    } t_emit_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/sfr_win_cell.sv -----
// One window cell: holds a pending byte and compares its candidate to a pattern byte.
`default_nettype none

module sfr_win_cell
    import sfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_win_ctl          i_ctl,
    input  wire logic              i_ins,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_pat,
    input  wire logic [BYTE_W-1:0] i_next,
    output logic      [BYTE_W-1:0] o_cand,
    output logic                   o_eq
);

    logic [BYTE_W-1:0] r_byte;

    // candidate: the incoming byte lands in the cell at the fill position
    assign o_cand = i_ins ? i_byte : r_byte;
    assign o_eq   = (o_cand == i_pat);

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_byte <= i_ctl.shift ? i_next : o_cand;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sfr_emit_cell.sv -----
// One output lane: holds a burst byte and moves it toward the head lane.
`default_nettype none

module sfr_emit_cell
    import sfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_emit_ctl         i_ctl,
    input  wire logic [BYTE_W-1:0] i_load,
    input  wire logic [BYTE_W-1:0] i_next,
    output logic      [BYTE_W-1:0] o_byte
);

    logic [BYTE_W-1:0] r_byte;

    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_load;
        end else if (i_ctl.pop) begin
            r_byte <= i_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stream_find_replace_core.sv -----
// Top level of the streaming find-and-replace block.
//
// Source bytes enter on the s_axis channel (tdata = byte, tlast = end of text).
// Rewritten bytes leave on the m_axis channel: tdata = byte, tlast = last result
// caused by one input item, tuser[0] = byte is data (0 only on an empty end
// marker), tuser[1] = final result of the whole text.
// The cfg port (we, index, data) sets pattern, pattern length, replacement and
// replacement length; writing the pattern length drops any pending window.
// Latency: the first result of an item is presented the cycle after it is taken.
// Throughput: one item per cycle while each item gives at most one result and the receiver is ready.
// An item that gives n results (replacement burst or end-of-text flush) holds
// the single output head lane until all n have left; the next item is taken
// in the cycle its last result leaves; items with no result hold no lane.
// A stalled receiver holds the output lanes; the input stays ready only while
// the lanes are empty or their final result is being taken.
// Reset (synchronous, active low) empties window and output lanes and loads
// pattern 0, pattern length 1, empty replacement.
`default_nettype none

module stream_find_replace_core
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // source stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] src_byte
    input  wire logic                 i_s_axis_tlast,   // src_last
    // rewritten stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [BYTE_W-1:0]    o_m_axis_tdata,   // [7:0] out_byte
    output logic                      o_m_axis_tlast,   // run_last
    output logic      [1:0]           o_m_axis_tuser,   // [0] out_valid, [1] text_end
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CW    = $clog2(BURST + 1);
    localparam int PW    = $clog2(MAX_PATTERN + 1);
    localparam int RW    = (MAX_REPLACEMENT < 1) ? 1 : $clog2(MAX_REPLACEMENT + 1);

    // configuration
    logic [CFG_W-1:0] r_pat;
    logic [CFG_W-1:0] r_rep;
    logic [PW-1:0]    r_plen;
    logic [RW-1:0]    r_rlen;
    logic [PW-1:0]    n_plen;
    logic [RW-1:0]    n_rlen;
    logic [LEN_IN_W-1:0] w_len_in;

    // window
    logic [PW-1:0]     r_wcnt;
    logic [BYTE_W-1:0] w_cand [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;
    t_win_ctl          w_wctl;
    logic w_full, w_match, w_last, w_s_acc;

    // output lanes
    logic [CW-1:0]     r_ecnt;
    logic              r_ev;
    logic              r_end;
    logic [CW-1:0]     n_raw;
    logic              w_marker;
    logic [BYTE_W-1:0] w_lane [BURST];
    logic [BYTE_W-1:0] w_load [BURST];
    t_emit_ctl         w_ectl;
    logic              w_pop;

    // ---------------- configuration registers ----------------
    assign w_len_in = i_cfg_data[LEN_IN_W-1:0];

    always_comb begin
        if (w_len_in == '0) begin
            n_plen = PW'(1);
        end else if (32'(w_len_in) > MAX_PATTERN) begin
            n_plen = PW'(MAX_PATTERN);
        end else begin
            n_plen = PW'(w_len_in);
        end
        if (32'(w_len_in) > MAX_REPLACEMENT) begin
            n_rlen = RW'(MAX_REPLACEMENT);
        end else begin
            n_rlen = RW'(w_len_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_rep  <= '0;
            r_plen <= PW'(1);
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PATTERN_BYTES:     r_pat  <= i_cfg_data;
                REG_PATTERN_LEN:       r_plen <= n_plen;
                REG_REPLACEMENT_BYTES: r_rep  <= i_cfg_data;
                REG_REPLACEMENT_LEN:   r_rlen <= n_rlen;
                default: ;
            endcase
        end
    end

    // ---------------- window cells ----------------
    assign w_s_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign w_last  = i_s_axis_tlast;

    // window holds pattern_len - 1 bytes at most, so the new byte fills it
    assign w_full = (r_wcnt == (r_plen - PW'(1)));

    always_comb begin
        w_match = w_full;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((PW'(i) < r_plen) && !w_eq[i]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_wctl.accept = w_s_acc;
    assign w_wctl.shift  = w_full & ~w_match;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_win
        logic [BYTE_W-1:0] w_next;
        if (g == MAX_PATTERN - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cand[g+1];
        end
        sfr_win_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_wctl),
            .i_ins  (r_wcnt == PW'(g)),
            .i_byte (i_s_axis_tdata),
            .i_pat  (r_pat[BYTE_W*g +: BYTE_W]),
            .i_next (w_next),
            .o_cand (w_cand[g]),
            .o_eq   (w_eq[g])
        );
    end

    // match, end of text or a pattern-length write empties the window; mismatch keeps the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
        end else if (i_cfg_we && (i_cfg_index == REG_PATTERN_LEN)) begin
            r_wcnt <= '0;
        end else if (w_s_acc) begin
            if (w_last || w_match) begin
                r_wcnt <= '0;
            end else if (!w_full) begin
                r_wcnt <= r_wcnt + PW'(1);
            end
        end
    end

    // ---------------- burst formation ----------------
    always_comb begin
        if (w_match) begin
            n_raw = CW'(r_rlen);
        end else if (w_full) begin
            n_raw = w_last ? CW'(r_plen) : CW'(1);
        end else begin
            n_raw = w_last ? (CW'(r_wcnt) + CW'(1)) : '0;
        end
    end

    // only a deleted match on the final item leaves nothing to send
    assign w_marker = w_last & (n_raw == '0);

    for (genvar g = 0; g < BURST; g++) begin : g_load
        logic [BYTE_W-1:0] w_win_byte;
        if (g < MAX_PATTERN) begin : g_w
            assign w_win_byte = w_cand[g];
        end else begin : g_z
            assign w_win_byte = '0;
        end
        assign w_load[g] = w_marker ? '0 :
                           w_match  ? r_rep[BYTE_W*g +: BYTE_W] : w_win_byte;
    end

    // ---------------- output lanes ----------------
    assign w_pop       = o_m_axis_tvalid & i_m_axis_tready;
    assign w_ectl.pop  = w_pop;
    assign w_ectl.load = w_s_acc & ((n_raw != '0) | w_last);

    for (genvar g = 0; g < BURST; g++) begin : g_emit
        logic [BYTE_W-1:0] w_next;
        if (g == BURST - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_lane[g+1];
        end
        sfr_emit_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ectl),
            .i_load (w_load[g]),
            .i_next (w_next),
            .o_byte (w_lane[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecnt <= '0;
            r_ev   <= 1'b0;
            r_end  <= 1'b0;
        end else if (w_ectl.load) begin
            r_ecnt <= w_marker ? CW'(1) : n_raw;
            r_ev   <= ~w_marker;
            r_end  <= w_last;
        end else if (w_pop) begin
            r_ecnt <= r_ecnt - CW'(1);
        end
    end

    // take a new item while the lanes are empty or their last result leaves
    assign o_s_axis_tready = (r_ecnt == '0) | ((r_ecnt == CW'(1)) & i_m_axis_tready);

    assign o_m_axis_tvalid   = (r_ecnt != '0);
    assign o_m_axis_tdata    = w_lane[0];
    assign o_m_axis_tlast    = (r_ecnt == CW'(1));
    assign o_m_axis_tuser[0] = r_ev;
    assign o_m_axis_tuser[1] = r_end & o_m_axis_tlast;

    // ---------------- assertions ----------------
    a_wcnt_below_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt < r_plen)
        else $error("window count reached pattern length");

    a_ecnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ecnt) <= BURST)
        else $error("burst count exceeds lane count");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_last) |=> (r_wcnt == '0))
        else $error("window not empty after end of text");

    a_marker_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tuser[1])
        else $error("empty marker outside end of text");

endmodule

`default_nettype wire
